[rtl/itb_pkg.sv]
// Shared types and constants for the indexed software timer bank.
`default_nettype none

package itb_pkg;

  localparam int CntW = 16;
  localparam int IdxW = 3;
  localparam int CmdW = 3;
  // Highest number of timers that an index can reach.
  localparam int IdxSpan = 1 << IdxW;

  localparam logic [CmdW-1:0] CmdNone  = 3'd0;
  localparam logic [CmdW-1:0] CmdInit  = 3'd1;
  localparam logic [CmdW-1:0] CmdReset = 3'd2;
  localparam logic [CmdW-1:0] CmdStop  = 3'd3;
  localparam logic [CmdW-1:0] CmdQuery = 3'd4;

  typedef struct packed {
    logic stopped;
    logic expired;
  } itb_status_t;

endpackage

`default_nettype wire

[rtl/itb_bank.sv]
// Timer state: counters, reload values and run flags, with tick and command update.
`default_nettype none

module itb_bank import itb_pkg::*; #(
  parameter int NUM_TIMERS = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            upd_en_i,
  input  wire logic [CmdW-1:0] cmd_i,
  input  wire logic [IdxW-1:0] idx_i,
  input  wire logic [CntW-1:0] reload_i,
  input  wire logic            tick_i,
  output itb_status_t          status_o
);

  localparam int NumAddr = (NUM_TIMERS < IdxSpan) ? NUM_TIMERS : IdxSpan;

  logic [CntW-1:0]    count_q [NUM_TIMERS];
  logic [CntW-1:0]    count_d [NUM_TIMERS];
  logic [CntW-1:0]    reload_q [NumAddr];
  logic [CntW-1:0]    reload_d [NumAddr];
  logic [NumAddr-1:0] run_q;
  logic [NumAddr-1:0] run_d;

  always_comb begin
    // tick first: every nonzero counter steps down, running or not
    for (int t = 0; t < NUM_TIMERS; t++) begin
      count_d[t] = count_q[t];
      if (tick_i && (count_q[t] != '0)) begin
        count_d[t] = count_q[t] - CntW'(1);
      end
    end
    run_d = run_q;
    for (int a = 0; a < NumAddr; a++) begin
      reload_d[a] = reload_q[a];
      if (idx_i == IdxW'(a)) begin
        case (cmd_i)
          CmdInit: begin
            reload_d[a] = reload_i;
            count_d[a]  = reload_i;
            run_d[a]    = 1'b1;
          end
          CmdReset: begin
            count_d[a] = reload_q[a];
            run_d[a]   = 1'b1;
          end
          CmdStop: begin
            run_d[a] = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Report the addressed timer after the update; an index beyond the bank reads as stopped.
  always_comb begin
    status_o.stopped = 1'b1;
    status_o.expired = 1'b0;
    for (int a = 0; a < NumAddr; a++) begin
      if (idx_i == IdxW'(a)) begin
        status_o.stopped = ~run_d[a];
        status_o.expired = run_d[a] && (count_d[a] == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        count_q[t] <= '0;
      end
      for (int a = 0; a < NumAddr; a++) begin
        reload_q[a] <= '0;
      end
      run_q <= '0;
    end else if (upd_en_i) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        count_q[t] <= count_d[t];
      end
      for (int a = 0; a < NumAddr; a++) begin
        reload_q[a] <= reload_d[a];
      end
      run_q <= run_d;
    end
  end

  a_status_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(status_o.stopped && status_o.expired))
    else $error("timer reported both stopped and expired");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_en_i |=> $stable(count_q[0]) && $stable(run_q))
    else $error("timer state changed without an accepted beat");

  a_tick_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_en_i && tick_i && (count_q[0] != '0) &&
     !((idx_i == '0) && ((cmd_i == CmdInit) || (cmd_i == CmdReset))))
    |=> (count_q[0] == $past(count_q[0]) - CntW'(1)))
    else $error("timer 0 did not step down on tick");

  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_en_i && (cmd_i == CmdStop) && (idx_i == '0)) |=> !run_q[0])
    else $error("timer 0 still running after stop");

endmodule

`default_nettype wire

[rtl/indexed_software_timer_bank.sv]
// Top level: input handshake, timer bank and registered result.
// A result is registered and valid in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the result is taken; the result register frees itself as it is taken.
// The bank updates all counters and the addressed timer in the accepting cycle.
// Reset (rst_ni low, asynchronous) clears all counts, reload values and run flags,
// leaving every timer stopped, and empties the result register.
`default_nettype none

module indexed_software_timer_bank import itb_pkg::*; #(
  parameter int NUM_TIMERS = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [CmdW-1:0] cmd_i,
  input  wire logic [IdxW-1:0] tmr_sel_i,
  input  wire logic [CntW-1:0] reload_value_i,
  input  wire logic            tick_elapsed_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 is_stopped_o,
  output logic                 is_expired_o
);

  logic        accept;
  logic        out_valid_q;
  itb_status_t status;
  itb_status_t res_q;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  itb_bank #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_en_i(accept),
    .cmd_i   (cmd_i),
    .idx_i   (tmr_sel_i),
    .reload_i(reload_value_i),
    .tick_i  (tick_elapsed_i),
    .status_o(status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign is_stopped_o = res_q.stopped;
  assign is_expired_o = res_q.expired;

endmodule

`default_nettype wire
